FILE: rtl/core/sgmpa_pkg.sv
// Package: shared constants and register codes of the SGM path cost aggregation block.
`timescale 1ns / 1ps
`default_nettype none

package sgmpa_pkg;

  // Disparity range of one pixel; storage and counters follow from it.
  localparam int unsigned MaxDisparities = 64;
  localparam int unsigned DispW          = $clog2(MaxDisparities);
  localparam int unsigned CountW         = DispW + 1;

  // Fixed field widths.
  localparam int unsigned MatchW   = 10;
  localparam int unsigned PenW     = 10;
  localparam int unsigned CostW    = 12;
  localparam int unsigned DispIdxW = 6;
  // Widest intermediate: minimum + penalty + matching cost.
  localparam int unsigned SumW     = 14;

  // Stream payload widths, rounded up to whole bytes.
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  localparam int unsigned CfgAddrW = 1;

  localparam logic [CostW-1:0] CostMax         = '1;
  localparam logic [PenW-1:0]  SmallPenaltyRst = 10'd15;
  localparam logic [PenW-1:0]  LargePenaltyRst = 10'd100;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SMALL_PENALTY = 1'b0,
    REG_LARGE_PENALTY = 1'b1
  } cfg_reg_e;

endpackage

`default_nettype wire

FILE: rtl/core/sgm_path_cost_aggregation.sv
// Top level: semi-global matching cost aggregation along one path, one disparity per cycle unless the output is held.
`timescale 1ns / 1ps
`default_nettype none
// An accepted input transaction's result is in the output register in the next cycle.
// Throughput: 1 transaction per cycle while the output is not held; the cost line store is read once per cycle at the
//   disparity after the next one, so both neighbors of a disparity are ready on arrival.
// Reset (rst_ni, async, active low) clears all control state, penalties go to 15 and 100.
// The cost line store is not cleared: entries are only used below the stored pixel width.

module sgm_path_cost_aggregation (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Configuration write port
  input  wire logic                                 cfg_we_i,
  input  wire logic [sgmpa_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  wire logic [sgmpa_pkg::PenW-1:0]           cfg_data_i,
  // Input stream: one matching cost per transaction
  input  wire logic                                 s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  input  wire logic [sgmpa_pkg::InDataW-1:0]        s_axis_tdata_i,  // [9:0] match_cost
  input  wire logic                                 s_axis_tuser_i,  // path_start
  input  wire logic                                 s_axis_tlast_i,  // pixel_end
  // Output stream: one path cost per transaction
  output logic                                      m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  output logic [sgmpa_pkg::OutDataW-1:0]            m_axis_tdata_o,  // [11:0] path_cost,
                                                                     // [17:12] disparity_index
  output logic                                      m_axis_tlast_o   // pixel_last
);

  localparam int unsigned DispW    = sgmpa_pkg::DispW;
  localparam int unsigned CountW   = sgmpa_pkg::CountW;
  localparam int unsigned CostW    = sgmpa_pkg::CostW;
  localparam int unsigned MatchW   = sgmpa_pkg::MatchW;
  localparam int unsigned PenW     = sgmpa_pkg::PenW;
  localparam int unsigned SumW     = sgmpa_pkg::SumW;
  localparam int unsigned DispIdxW = sgmpa_pkg::DispIdxW;
  localparam int unsigned Depth    = 2 ** DispW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PenW-1:0] small_pen_q, large_pen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_pen_q <= sgmpa_pkg::SmallPenaltyRst;
      large_pen_q <= sgmpa_pkg::LargePenaltyRst;
    end else if (cfg_we_i) begin
      case (sgmpa_pkg::cfg_reg_e'(cfg_addr_i))
        sgmpa_pkg::REG_SMALL_PENALTY: small_pen_q <= cfg_data_i;
        sgmpa_pkg::REG_LARGE_PENALTY: large_pen_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: single output register, input stalls only when it is full and held
  // ---------------------------------------------------------------------------
  logic m_valid_q;
  logic accept;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------------------------
  // Path state
  // ---------------------------------------------------------------------------
  logic [DispW-1:0]  cnt_q, cnt_d;        // disparity of the next cost
  logic [CountW-1:0] prev_cnt_q;          // width of the previous pixel
  logic [CostW-1:0]  prev_min_q;          // minimum over the previous pixel
  logic [CostW-1:0]  run_min_q;           // minimum of the current pixel so far
  logic [CostW-1:0]  held_q;              // previous pixel's entry at d-1
  logic              first_q;             // current pixel is a path start
  logic [CostW-1:0]  first_entry_q;       // entry 0, kept outside the store
  logic [CostW-1:0]  nxt_entry_q;         // previous pixel's entry at d (d >= 1)

  // Cost line store, read one disparity ahead
  logic [CostW-1:0]  mem_q [Depth];
  logic [CostW-1:0]  rd_raw_q;
  logic [CostW-1:0]  byp_data_q;
  logic              byp_q;
  logic [CostW-1:0]  rd_data;             // previous pixel's entry at d+1
  logic [DispW-1:0]  raddr;

  // ---------------------------------------------------------------------------
  // Per-disparity datapath
  // ---------------------------------------------------------------------------
  logic [DispW-1:0]  d;
  logic              d_is0;
  logic [CountW-1:0] d_ext;
  logic              first_eff;
  logic [CostW-1:0]  old_entry;
  logic              use_same, use_lo, use_hi;
  logic [SumW-1:0]   t_large, t_lo, t_hi, best;
  logic [SumW-1:0]   pre_sub, raw;
  logic [CostW-1:0]  result;
  logic [CostW-1:0]  run_min_new;
  logic              last;

  assign rd_data = byp_q ? byp_data_q : rd_raw_q;

  always_comb begin
    d         = cnt_q;
    d_is0     = (d == '0);
    d_ext     = CountW'(d);
    // path_start only counts on disparity 0; an empty predecessor forces a start
    first_eff = first_q || (d_is0 && (s_axis_tuser_i || prev_cnt_q == '0));
    old_entry = d_is0 ? first_entry_q : nxt_entry_q;

    // Only disparities the previous pixel actually had take part
    use_same  = d_ext < prev_cnt_q;
    use_lo    = !d_is0 && (d_ext <= prev_cnt_q);
    // prev_cnt_q never exceeds the disparity range, so this also bounds d+1
    use_hi    = (d_ext + CountW'(1)) < prev_cnt_q;

    t_large   = SumW'(prev_min_q) + SumW'(large_pen_q);
    t_lo      = SumW'(held_q) + SumW'(small_pen_q);
    t_hi      = SumW'(rd_data) + SumW'(small_pen_q);

    best = t_large;
    if (use_same && SumW'(old_entry) < best) begin
      best = SumW'(old_entry);
    end
    if (use_lo && t_lo < best) begin
      best = t_lo;
    end
    if (use_hi && t_hi < best) begin
      best = t_hi;
    end

    // Every used term is at least the previous minimum, so the subtract never wraps
    pre_sub = SumW'(s_axis_tdata_i[MatchW-1:0]) + best;
    raw     = first_eff ? SumW'(s_axis_tdata_i[MatchW-1:0])
                        : pre_sub - SumW'(prev_min_q);
    result  = (raw > SumW'(sgmpa_pkg::CostMax)) ? sgmpa_pkg::CostMax : raw[CostW-1:0];

    run_min_new = (result < run_min_q) ? result : run_min_q;
    // Too many disparities: the top one closes the pixel
    last = s_axis_tlast_i || (d == DispW'(sgmpa_pkg::MaxDisparities - 1));

    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = last ? '0 : d + DispW'(1);
    end
    // Prefetch the entry after the next disparity; wraps harmlessly at the top
    raddr = cnt_d + DispW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      prev_cnt_q <= '0;
      prev_min_q <= '0;
      run_min_q  <= sgmpa_pkg::CostMax;
      held_q     <= '0;
      first_q    <= 1'b1;
      byp_q      <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      byp_q <= accept && (d == raddr);
      if (accept) begin
        held_q <= old_entry;
        if (last) begin
          prev_cnt_q <= d_ext + CountW'(1);
          prev_min_q <= run_min_new;
          run_min_q  <= sgmpa_pkg::CostMax;
          first_q    <= 1'b0;
        end else begin
          run_min_q  <= run_min_new;
          first_q    <= first_eff;
        end
      end
    end
  end

  // Store and its one-ahead read; a same-address write is forwarded via byp_q
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[d] <= result;
    end
    rd_raw_q   <= mem_q[raddr];
    byp_data_q <= result;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      nxt_entry_q <= rd_data;
      if (d_is0) begin
        first_entry_q <= result;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [CostW-1:0]          out_cost_q;
  logic [DispIdxW-1:0]       out_disp_q;
  logic                      out_last_q;
  logic [DispIdxW+DispW-1:0] d_wide;

  assign d_wide = (DispIdxW + DispW)'(d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_cost_q <= result;
      out_disp_q <= d_wide[DispIdxW-1:0];
      out_last_q <= last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = sgmpa_pkg::OutDataW'({out_disp_q, out_cost_q});
  assign m_axis_tlast_o  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !first_eff |-> pre_sub >= SumW'(prev_min_q))
    else $error("path cost term below previous minimum");

  a_cnt_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> cnt_q == '0 && !first_q)
    else $error("disparity counter not restarted after pixel close");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !last |=> cnt_q == $past(cnt_q) + DispW'(1))
    else $error("disparity counter did not advance");

  a_prev_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> prev_min_q <= $past(result))
    else $error("previous minimum above a closing cost");

endmodule

`default_nettype wire
